@@ rtl/core/cbc_pkg.sv @@
// Package for the cartridge bank controller: controller kinds, action codes,
// register indexes, address regions and the header decode functions.
// No dependencies.
`default_nettype none

package cbc_pkg;

    typedef logic [1:0] t_action;
    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_cfg_index;

    localparam t_action ACT_READ    = 2'd0;
    localparam t_action ACT_WRITE   = 2'd1;
    localparam t_action ACT_PRELOAD = 2'd2;

    localparam t_kind KIND_NONE = 3'd0;
    localparam t_kind KIND_MBC1 = 3'd1;
    localparam t_kind KIND_MBC2 = 3'd2;
    localparam t_kind KIND_MBC3 = 3'd3;
    localparam t_kind KIND_MBC5 = 3'd4;

    localparam t_cfg_index CFG_CART_TYPE   = 2'd0;
    localparam t_cfg_index CFG_ROM_SIZE    = 2'd1;
    localparam t_cfg_index CFG_RAM_SIZE    = 2'd2;
    localparam t_cfg_index CFG_ROM_LOADED  = 2'd3;

    // Address regions by bus_address[15:13]
    localparam logic [2:0] RGN_RAM_ENABLE = 3'd0;
    localparam logic [2:0] RGN_ROM_BANK   = 3'd1;
    localparam logic [2:0] RGN_UPPER_BANK = 3'd2;
    localparam logic [2:0] RGN_MODE       = 3'd3;
    localparam logic [2:0] RGN_EXT_RAM    = 3'd5;

    localparam int BANK_W     = 9;   // ROM bank register width
    localparam int LOAD_W     = 6;   // loaded-length register width
    localparam int ROM_OFF_W  = 14;  // offset inside a 16 KiB bank
    localparam int RAM_OFF_W  = 13;  // offset inside an 8 KiB bank
    localparam int ROM_BYTE_W = 24;  // wide enough for any ROM byte index

    function automatic t_kind cart_kind(input logic [7:0] t);
        t_kind k;
        k = KIND_NONE;
        if (t >= 8'h01 && t <= 8'h03) begin
            k = KIND_MBC1;
        end else if (t == 8'h05 || t == 8'h06) begin
            k = KIND_MBC2;
        end else if (t >= 8'h0F && t <= 8'h13) begin
            k = KIND_MBC3;
        end else if (t >= 8'h19 && t <= 8'h1E) begin
            k = KIND_MBC5;
        end
        return k;
    endfunction

    // Bank count is a power of two, so the modulo is a mask
    function automatic logic [BANK_W-1:0] rom_bank_mask(input logic [7:0] code);
        logic [BANK_W:0] m;
        m = '0;
        if (code <= 8'd8) begin
            m = (10'd2 << code[3:0]) - 10'd1;
        end else begin
            m = 10'h07F;
        end
        return m[BANK_W-1:0];
    endfunction

    function automatic logic [4:0] ram_bank_count(input logic [7:0] code);
        logic [4:0] n;
        case (code)
            8'd1:    n = 5'd1;
            8'd2:    n = 5'd1;
            8'd3:    n = 5'd4;
            8'd4:    n = 5'd16;
            8'd5:    n = 5'd8;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cbc_in_if.sv @@
// Input channel of the cartridge bank controller: valid/ready plus one item.
// Depends on cbc_pkg.
`default_nettype none

interface cbc_in_if;
    import cbc_pkg::*;

    logic          valid;
    logic          ready;
    t_action       action;
    logic [15:0]   bus_address;
    logic [7:0]    bus_data;
    logic [18:0]   rom_load_index;

    modport source (
        output valid, action, bus_address, bus_data, rom_load_index,
        input  ready
    );
    modport sink (
        input  valid, action, bus_address, bus_data, rom_load_index,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/cbc_out_if.sv @@
// Output channel of the cartridge bank controller: valid/ready plus read data.
// No dependencies.
`default_nettype none

interface cbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (
        output valid, read_data,
        input  ready
    );
    modport sink (
        input  valid, read_data,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/cbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/cartridge_bank_controller.sv @@
// Cartridge bank controller top level: bank registers, header decode,
// shared bank-modulo unit, ROM and RAM stores. Depends on cbc_pkg,
// cbc_in_if, cbc_out_if and cbc_ram.
//
//  Channel   Dir  Handshake              Carries
//  i_in      in   valid/ready            action, bus_address, bus_data, rom_load_index
//  o_out     out  valid/ready            read_data
//  i_cfg_*   in   i_cfg_we (no wait)     i_cfg_index, i_cfg_data
//
// Writes and preloads are taken in the idle state and do not leave it. A read of ROM
// 0x0000-0x3FFF or of external RAM passes through the memory and take states, an
// unmapped or disabled read goes straight to the take state, and a banked ROM read
// goes through the divide state before them: the bank is reduced modulo the loaded
// length by a restoring divider, one bit per cycle for the 9 bank bits, then the ROM
// port is read. While busy, i_in.ready is low. After reset the RAM store is swept
// to zero with i_in.ready low; configuration writes are taken during the sweep.
// A pending result waits in the output register; the next item is accepted.
`default_nettype none

module cartridge_bank_controller #(
    parameter int ROM_BANKS = 32,
    parameter int RAM_BANKS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    cbc_in_if.sink                     i_in,
    cbc_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire cbc_pkg::t_cfg_index   i_cfg_index,
    input  wire logic [7:0]            i_cfg_data
);
    import cbc_pkg::*;

    localparam int ROM_DEPTH = ROM_BANKS * 16384;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int RAM_DEPTH = RAM_BANKS * 8192;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int ROM_CAP_I = (ROM_BANKS < 63) ? ROM_BANKS : 63;
    localparam int CNT_W     = $clog2(BANK_W);

    localparam logic [ROM_BYTE_W-1:0] ROM_LIMIT = ROM_BYTE_W'(ROM_DEPTH);
    localparam logic [LOAD_W-1:0]     ROM_CAP   = LOAD_W'(ROM_CAP_I);
    localparam logic [4:0]            RAM_CAP   = 5'(RAM_BANKS);
    localparam logic [RAM_AW-1:0]     RAM_LAST  = RAM_AW'(RAM_DEPTH - 1);
    localparam logic [CNT_W-1:0]      DIV_LAST  = CNT_W'(BANK_W - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MEM   = 3'd3;
    localparam logic [2:0] S_TAKE  = 3'd4;

    // Control and configuration state
    logic [2:0]           r_state, n_state;
    logic [RAM_AW-1:0]    r_clr_addr;
    logic [7:0]           r_hdr_type, r_hdr_rom, r_hdr_ram;
    logic [LOAD_W-1:0]    r_rom_loaded;
    logic [BANK_W-1:0]    r_rom_bank, n_rom_bank;
    logic [3:0]           r_ram_bank, n_ram_bank;
    logic                 r_mode, n_mode;
    logic                 r_ram_en, n_ram_en;
    logic                 r_out_valid;

    // Item datapath
    logic [7:0]           r_out_data;
    logic [BANK_W-1:0]    r_dvd;
    logic [LOAD_W-1:0]    r_rem;
    logic [LOAD_W-1:0]    r_divisor;
    logic [CNT_W-1:0]     r_cnt;
    logic [ROM_OFF_W-1:0] r_low14;
    logic [ROM_AW-1:0]    r_rom_raddr;
    logic [RAM_AW-1:0]    r_ram_raddr;
    logic                 r_sel_ram;
    logic                 r_ff;

    t_kind                w_kind;
    logic                 w_mbc1_mode1;
    logic                 w_acc;
    logic                 w_out_free;
    logic [4:0]           w_ram_n;
    logic [4:0]           w_ram_lim;
    logic [3:0]           w_rd_ram_bank;
    logic [3:0]           w_wr_ram_bank;
    logic                 w_rd_ram_ok;
    logic                 w_wr_ram_ok;
    logic [16:0]          w_rd_ram_addr17;
    logic [16:0]          w_wr_ram_addr17;
    logic [BANK_W-1:0]    w_bank;
    logic [LOAD_W-1:0]    w_divisor;
    logic [LOAD_W:0]      w_trial;
    logic                 w_fits;
    logic [LOAD_W-1:0]    w_rem_next;
    logic [22:0]          w_rom_hi_addr;
    logic [ROM_BYTE_W-1:0] w_load_idx;
    logic                 w_rom_we;
    logic                 w_ram_we;
    logic [RAM_AW-1:0]    w_ram_waddr;
    logic [7:0]           w_ram_wdata;
    logic [7:0]           w_rom_rdata;
    logic [7:0]           w_ram_rdata;
    logic [4:0]           w_b5;
    logic [6:0]           w_b7;
    logic [3:0]           w_b4;
    logic                 w_en_val;

    assign w_kind       = cart_kind(r_hdr_type);
    assign w_mbc1_mode1 = (w_kind == KIND_MBC1) && r_mode;
    assign w_acc        = i_in.valid && i_in.ready;
    assign w_out_free   = !r_out_valid || o_out.ready;

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;

    // RAM bank and limit decode
    always_comb begin
        w_ram_n   = ram_bank_count(r_hdr_ram);
        w_ram_lim = w_ram_n;
        if (w_ram_n == 5'd0) begin
            w_ram_lim = 5'd1;
        end else if (w_ram_n > RAM_CAP) begin
            w_ram_lim = RAM_CAP;
        end
        w_rd_ram_bank = 4'd0;
        if (w_mbc1_mode1) begin
            w_rd_ram_bank = r_ram_bank;
            if (w_ram_n != 5'd0) begin
                w_rd_ram_bank = r_ram_bank & 4'(w_ram_n - 5'd1);
            end
        end
        w_wr_ram_bank = 4'd0;
        if (w_mbc1_mode1 && w_ram_n > 5'd1) begin
            w_wr_ram_bank = r_ram_bank;
        end
        w_rd_ram_ok     = r_ram_en && ({1'b0, w_rd_ram_bank} < w_ram_lim);
        w_wr_ram_ok     = r_ram_en && ({1'b0, w_wr_ram_bank} < w_ram_lim);
        w_rd_ram_addr17 = {w_rd_ram_bank, i_in.bus_address[RAM_OFF_W-1:0]};
        w_wr_ram_addr17 = {w_wr_ram_bank, i_in.bus_address[RAM_OFF_W-1:0]};
    end

    // ROM bank for the switchable window, and the clamped loaded length
    always_comb begin
        w_bank = r_rom_bank;
        if (w_kind == KIND_MBC1 && !r_mode && r_hdr_rom >= 8'd5) begin
            w_bank[5] = 1'b0;
        end
        w_bank = w_bank & rom_bank_mask(r_hdr_rom);
        if (w_bank == '0) begin
            w_bank = BANK_W'(1);
        end
        w_divisor = r_rom_loaded;
        if (r_rom_loaded < LOAD_W'(2)) begin
            w_divisor = LOAD_W'(2);
        end else if (r_rom_loaded > ROM_CAP) begin
            w_divisor = ROM_CAP;
        end
    end

    // One restoring-division step per cycle
    assign w_trial    = {r_rem, r_dvd[BANK_W-1]};
    assign w_fits     = w_trial >= {1'b0, r_divisor};
    assign w_rem_next = w_fits ? LOAD_W'(w_trial - {1'b0, r_divisor})
                               : w_trial[LOAD_W-1:0];
    assign w_rom_hi_addr = 23'({w_rem_next, r_low14});

    // Control writes
    always_comb begin
        n_rom_bank = r_rom_bank;
        n_ram_bank = r_ram_bank;
        n_mode     = r_mode;
        n_ram_en   = r_ram_en;
        w_en_val   = (i_in.bus_data[3:0] == 4'hA);
        w_b5 = (i_in.bus_data[4:0] == 5'd0) ? 5'd1 : i_in.bus_data[4:0];
        w_b7 = (i_in.bus_data[6:0] == 7'd0) ? 7'd1 : i_in.bus_data[6:0];
        w_b4 = (i_in.bus_data[3:0] == 4'd0) ? 4'd1 : i_in.bus_data[3:0];
        if (w_acc && i_in.action == ACT_WRITE) begin
            case (i_in.bus_address[15:13])
                RGN_RAM_ENABLE: begin
                    if (w_kind == KIND_MBC1 || w_kind == KIND_MBC3
                            || w_kind == KIND_MBC5) begin
                        n_ram_en = w_en_val;
                    end else if (w_kind == KIND_MBC2 && !i_in.bus_address[8]) begin
                        n_ram_en = w_en_val;
                    end
                end
                RGN_ROM_BANK: begin
                    if (w_kind == KIND_MBC1) begin
                        n_rom_bank = {2'b00, r_rom_bank[6:5], w_b5};
                    end else if (w_kind == KIND_MBC3) begin
                        n_rom_bank = {2'b00, w_b7};
                    end else if (w_kind == KIND_MBC5) begin
                        if (!i_in.bus_address[12]) begin
                            n_rom_bank = {r_rom_bank[8], i_in.bus_data};
                        end else begin
                            n_rom_bank = {i_in.bus_data[0], r_rom_bank[7:0]};
                        end
                    end else if (w_kind == KIND_MBC2 && i_in.bus_address[8]) begin
                        n_rom_bank = {5'b00000, w_b4};
                    end
                end
                RGN_UPPER_BANK: begin
                    if (w_kind == KIND_MBC1) begin
                        if (!r_mode) begin
                            n_rom_bank = {2'b00, i_in.bus_data[1:0], r_rom_bank[4:0]};
                        end else begin
                            n_ram_bank = {2'b00, i_in.bus_data[1:0]};
                        end
                    end else if (w_kind == KIND_MBC3) begin
                        n_ram_bank = {2'b00, i_in.bus_data[1:0]};
                    end else if (w_kind == KIND_MBC5) begin
                        n_ram_bank = i_in.bus_data[3:0];
                    end
                end
                RGN_MODE: begin
                    if (w_kind == KIND_MBC1) begin
                        n_mode = i_in.bus_data[0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Store write ports: sweep after reset, RAM writes, ROM preloads
    assign w_load_idx = ROM_BYTE_W'(i_in.rom_load_index);
    assign w_rom_we   = w_acc && i_in.action == ACT_PRELOAD && (w_load_idx < ROM_LIMIT);

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr_addr;
            w_ram_wdata = 8'h00;
        end else begin
            w_ram_we    = w_acc && i_in.action == ACT_WRITE
                          && i_in.bus_address[15:13] == RGN_EXT_RAM && w_wr_ram_ok;
            w_ram_waddr = w_wr_ram_addr17[RAM_AW-1:0];
            w_ram_wdata = i_in.bus_data;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == RAM_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc && i_in.action == ACT_READ) begin
                    if (i_in.bus_address[15:14] == 2'b01) begin
                        n_state = S_DIV;
                    end else if (i_in.bus_address[15:14] == 2'b00) begin
                        n_state = S_MEM;
                    end else if (i_in.bus_address[15:13] == RGN_EXT_RAM && w_rd_ram_ok) begin
                        n_state = S_MEM;
                    end else begin
                        n_state = S_TAKE;
                    end
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_MEM;
                end
            end
            S_MEM: begin
                n_state = S_TAKE;
            end
            S_TAKE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_hdr_type   <= 8'h00;
            r_hdr_rom    <= 8'h00;
            r_hdr_ram    <= 8'h00;
            r_rom_loaded <= LOAD_W'(2);
            r_rom_bank   <= BANK_W'(1);
            r_ram_bank   <= 4'd0;
            r_mode       <= 1'b0;
            r_ram_en     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rom_bank <= n_rom_bank;
            r_ram_bank <= n_ram_bank;
            r_mode     <= n_mode;
            r_ram_en   <= n_ram_en;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + RAM_AW'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CART_TYPE:  r_hdr_type   <= i_cfg_data;
                    CFG_ROM_SIZE:   r_hdr_rom    <= i_cfg_data;
                    CFG_RAM_SIZE:   r_hdr_ram    <= i_cfg_data;
                    CFG_ROM_LOADED: r_rom_loaded <= i_cfg_data[LOAD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_TAKE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.action == ACT_READ) begin
            r_low14     <= i_in.bus_address[ROM_OFF_W-1:0];
            r_rom_raddr <= ROM_AW'(i_in.bus_address[ROM_OFF_W-1:0]);
            r_ram_raddr <= w_rd_ram_addr17[RAM_AW-1:0];
            r_sel_ram   <= i_in.bus_address[15];
            r_ff        <= !(i_in.bus_address[15] == 1'b0
                             || (i_in.bus_address[15:13] == RGN_EXT_RAM && w_rd_ram_ok));
            r_dvd       <= w_bank;
            r_rem       <= '0;
            r_divisor   <= w_divisor;
            r_cnt       <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem <= w_rem_next;
            r_dvd <= {r_dvd[BANK_W-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == DIV_LAST) begin
                r_rom_raddr <= w_rom_hi_addr[ROM_AW-1:0];
            end
        end
        if (r_state == S_TAKE && w_out_free) begin
            if (r_ff) begin
                r_out_data <= 8'hFF;
            end else if (r_sel_ram) begin
                r_out_data <= w_ram_rdata;
            end else begin
                r_out_data <= w_rom_rdata;
            end
        end
    end

    cbc_ram #(
        .WIDTH (8),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (w_rom_we),
        .i_waddr (w_load_idx[ROM_AW-1:0]),
        .i_wdata (i_in.bus_data),
        .i_raddr (r_rom_raddr),
        .o_rdata (w_rom_rdata)
    );

    cbc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // The partial remainder stays below the divisor throughout the division
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_divisor)
        else $error("bank remainder not below loaded length");

    // An accepted read always leaves the idle state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_in.action == ACT_READ |=> r_state != S_IDLE)
        else $error("read item dropped");

    // A result is loaded only out of the take state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_TAKE)
        else $error("result produced outside take state");

    // RAM store is written only by the sweep or by an accepted item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_CLEAR || w_acc))
        else $error("stray RAM store write");

endmodule

`default_nettype wire

@@ dv/tb_cartridge_bank_controller.sv @@
// Self-checking testbench for cartridge_bank_controller: drives bus reads, writes and ROM
// preloads through several header settings and checks every read byte in order against
// a scoreboard that mirrors the banking rules. Depends on cbc_pkg, cbc_in_if and cbc_out_if.
`default_nettype none

import cbc_pkg::*;

class cart_scoreboard #(int ROM_BANKS = 32, int RAM_BANKS = 16);
    localparam int ROM_BYTES = ROM_BANKS * 16384;
    localparam int RAM_BYTES = RAM_BANKS * 8192;

    bit [7:0] rom_image [ROM_BYTES];
    bit       rom_known [ROM_BYTES];
    bit [7:0] ram_image [RAM_BYTES];
    bit [8:0] sel_rom_bank;
    bit [3:0] sel_ram_bank;
    bit       mbc1_mode;
    bit       ram_open;
    bit [7:0] cart_type;
    bit [7:0] rom_code;
    bit [7:0] ram_code;
    bit [5:0] loaded_banks;
    bit [7:0] read_bytes_due [$];
    int       mismatches;

    function new();
        sel_rom_bank = 9'd1;
        loaded_banks = 6'd2;
    endfunction

    function void set_reg(t_cfg_index idx, logic [7:0] value);
        case (idx)
            CFG_CART_TYPE:  cart_type = value;
            CFG_ROM_SIZE:   rom_code = value;
            CFG_RAM_SIZE:   ram_code = value;
            CFG_ROM_LOADED: loaded_banks = value[5:0];
            default: ;
        endcase
    endfunction

    function t_kind decoded_kind();
        case (cart_type)
            8'h01, 8'h02, 8'h03:                      return KIND_MBC1;
            8'h05, 8'h06:                             return KIND_MBC2;
            8'h0F, 8'h10, 8'h11, 8'h12, 8'h13:        return KIND_MBC3;
            8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E: return KIND_MBC5;
            default:                                  return KIND_NONE;
        endcase
    endfunction

    function int rom_banks_decoded();
        return (rom_code <= 8'd8) ? (2 << rom_code) : 128;
    endfunction

    function int ram_banks_decoded();
        case (ram_code)
            8'd1, 8'd2: return 1;
            8'd3:       return 4;
            8'd4:       return 16;
            8'd5:       return 8;
            default:    return 0;
        endcase
    endfunction

    function int ram_span();
        int n;
        n = ram_banks_decoded();
        if (n == 0) n = 1;
        if (n > RAM_BANKS) n = RAM_BANKS;
        return n * 8192;
    endfunction

    function int rom_span();
        int n;
        n = loaded_banks;
        if (n < 2) n = 2;
        if (n > ROM_BANKS) n = ROM_BANKS;
        return n * 16384;
    endfunction

    // ROM byte index that a read of addr (below 0x8000) lands on
    function int rom_offset(logic [15:0] addr);
        int bank;
        int off;
        if (!addr[14]) return int'(addr[13:0]);
        bank = sel_rom_bank;
        if (decoded_kind() == KIND_MBC1 && !mbc1_mode && rom_code >= 8'd5) bank[5] = 1'b0;
        bank = bank % rom_banks_decoded();
        if (bank == 0) bank = 1;
        off = int'(addr[13:0]) + bank * 16384;
        if (off >= rom_span()) off = off % rom_span();
        return off;
    endfunction

    function logic [7:0] read_byte(logic [15:0] addr);
        int off;
        int bank;
        int n;
        if (!addr[15]) return rom_image[rom_offset(addr)];
        if (addr[15:13] != RGN_EXT_RAM || !ram_open) return 8'hFF;
        off = int'(addr[12:0]);
        if (decoded_kind() == KIND_MBC1 && mbc1_mode) begin
            n = ram_banks_decoded();
            bank = sel_ram_bank;
            if (n > 0) bank = bank % n;
            off += bank * 8192;
        end
        return (off < ram_span()) ? ram_image[off] : 8'hFF;
    endfunction

    function void apply_write(logic [15:0] addr, logic [7:0] value);
        t_kind k;
        bit opens;
        logic [6:0] b;
        int off;
        k = decoded_kind();
        opens = (value[3:0] == 4'hA);
        case (addr[15:13])
            RGN_RAM_ENABLE: begin
                if (k == KIND_MBC1 || k == KIND_MBC3 || k == KIND_MBC5) ram_open = opens;
                else if (k == KIND_MBC2 && !addr[8]) ram_open = opens;
            end
            RGN_ROM_BANK: begin
                case (k)
                    KIND_MBC1: begin
                        b = {2'b00, value[4:0]};
                        if (b == 7'd0) b = 7'd1;
                        sel_rom_bank = {2'b00, sel_rom_bank[6:5], b[4:0]};
                    end
                    KIND_MBC3: begin
                        b = value[6:0];
                        if (b == 7'd0) b = 7'd1;
                        sel_rom_bank = {2'b00, b};
                    end
                    KIND_MBC5: begin
                        if (!addr[12]) sel_rom_bank = {sel_rom_bank[8], value};
                        else sel_rom_bank = {value[0], sel_rom_bank[7:0]};
                    end
                    KIND_MBC2: begin
                        if (addr[8]) begin
                            b = {3'b000, value[3:0]};
                            if (b == 7'd0) b = 7'd1;
                            sel_rom_bank = {2'b00, b};
                        end
                    end
                    default: ;
                endcase
            end
            RGN_UPPER_BANK: begin
                if (k == KIND_MBC1) begin
                    if (!mbc1_mode) sel_rom_bank = {2'b00, value[1:0], sel_rom_bank[4:0]};
                    else sel_ram_bank = {2'b00, value[1:0]};
                end else if (k == KIND_MBC3) begin
                    sel_ram_bank = {2'b00, value[1:0]};
                end else if (k == KIND_MBC5) begin
                    sel_ram_bank = value[3:0];
                end
            end
            RGN_MODE: begin
                if (k == KIND_MBC1) mbc1_mode = value[0];
            end
            RGN_EXT_RAM: begin
                if (ram_open) begin
                    off = int'(addr[12:0]);
                    if (k == KIND_MBC1 && mbc1_mode && ram_banks_decoded() > 1)
                        off += sel_ram_bank * 8192;
                    if (off < ram_span()) ram_image[off] = value;
                end
            end
            default: ;
        endcase
    endfunction

    function void note_item(t_action act, logic [15:0] addr, logic [7:0] data,
                            logic [18:0] idx);
        case (act)
            ACT_READ:  read_bytes_due.push_back(read_byte(addr));
            ACT_WRITE: apply_write(addr, data);
            ACT_PRELOAD: begin
                if (idx < ROM_BYTES) begin
                    rom_image[idx] = data;
                    rom_known[idx] = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_read(logic [7:0] got);
        logic [7:0] want;
        if (read_bytes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: read data %02h arrived with no read outstanding", $time, got);
            return;
        end
        want = read_bytes_due.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: read data mismatch: expected %02h, got %02h", $time, want, got);
        end
    endfunction
endclass

module tb_cartridge_bank_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROM_BANKS    = 32;
    localparam int RAM_BANKS    = 16;
    localparam int CLEAR_CYCLES = RAM_BANKS * 8192;
    localparam int STALL_LIMIT  = 2 * CLEAR_CYCLES + 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 64;
    localparam int PHASE_ITEMS  = 125;
    localparam int NUM_PHASES   = 9;
    localparam t_action ACT_UNUSED = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_index i_cfg_index;
    logic [7:0] i_cfg_data;

    cbc_in_if  in_ch ();
    cbc_out_if out_ch ();

    cart_scoreboard #(.ROM_BANKS(ROM_BANKS), .RAM_BANKS(RAM_BANKS)) cart_sb;

    int idle_pct;
    bit calm;
    bit long_hold_req;
    int items_sent;
    int quiet_cycles;

    cartridge_bank_controller #(
        .ROM_BANKS(ROM_BANKS),
        .RAM_BANKS(RAM_BANKS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offsets cluster at both ends of a bank so that bytes get reused
    function automatic logic [13:0] pooled_offset();
        logic [13:0] r;
        r = $urandom;
        if ($urandom_range(0, 1) == 0) r[12:3] = {10{r[13]}};
        return r;
    endfunction

    function automatic logic [15:0] rom_addr();
        logic [15:0] a;
        a = {2'b00, pooled_offset()};
        a[14] = $urandom_range(0, 1);
        return a;
    endfunction

    function automatic logic [15:0] ram_addr();
        logic [13:0] off;
        off = pooled_offset();
        return {RGN_EXT_RAM, off[12:0]};
    endfunction

    task automatic send_item(input t_action act, input logic [15:0] addr,
                             input logic [7:0] data, input logic [18:0] idx);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.action         <= act;
        in_ch.bus_address    <= addr;
        in_ch.bus_data       <= data;
        in_ch.rom_load_index <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
        cart_sb.note_item(act, addr, data, idx);
        if (act != ACT_UNUSED) items_sent++;
    endtask

    task automatic write_at(input logic [15:0] addr, input logic [7:0] data);
        send_item(ACT_WRITE, addr, data, $urandom);
    endtask

    // Preload the ROM byte a read will land on if it was never written
    task automatic read_at(input logic [15:0] addr);
        int off;
        if (!addr[15]) begin
            off = cart_sb.rom_offset(addr);
            if (!cart_sb.rom_known[off]) send_item(ACT_PRELOAD, $urandom, $urandom, off);
        end
        send_item(ACT_READ, addr, $urandom, $urandom);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        cart_sb.set_reg(idx, value);
    endtask

    task automatic load_config(input logic [7:0] cart, input logic [7:0] rom_sz,
                               input logic [7:0] ram_sz, input logic [7:0] loaded);
        write_reg(CFG_CART_TYPE, cart);
        write_reg(CFG_ROM_SIZE, rom_sz);
        write_reg(CFG_RAM_SIZE, ram_sz);
        write_reg(CFG_ROM_LOADED, loaded);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (cart_sb.read_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Runs under MBC1, 64 ROM banks, 4 RAM banks, full 32-bank load
    task automatic directed();
        send_item(ACT_PRELOAD, 16'h0000, 8'h00, 19'h00000);
        send_item(ACT_PRELOAD, 16'hFFFF, 8'hFF, 19'h7FFFF);
        read_at(16'h0000);
        read_at(16'hFFFF);
        read_at(16'h8000);
        read_at(16'hA000);             // RAM still disabled
        write_at(16'h0000, 8'h0A);
        write_at(16'hA000, 8'h5A);
        write_at(16'hBFFF, 8'hFF);
        read_at(16'hA000);
        read_at(16'hBFFF);
        write_at(16'h2000, 8'h00);     // bank 0 selects bank 1
        read_at(16'h4000);
        write_at(16'h3FFF, 8'h1F);
        write_at(16'h4000, 8'h01);     // upper ROM bits while in mode 0
        read_at(16'h7FFF);             // bit 5 dropped for a large ROM in mode 0
        write_at(16'h6000, 8'h01);
        read_at(16'h7FFF);             // bank 63 wraps onto the last loaded byte
        write_at(16'h4000, 8'h03);     // RAM bank 3 in mode 1
        write_at(16'hA000, 8'h77);
        read_at(16'hA000);
        write_at(16'h4000, 8'h00);
        read_at(16'hA000);
        write_at(16'h1FFF, 8'h00);     // disable RAM, then write is dropped
        write_at(16'hA000, 8'h11);
        read_at(16'hA000);
        send_item(ACT_UNUSED, 16'hFFFF, 8'hFF, 19'h7FFFF);
    endtask

    task automatic random_item();
        int pick;
        logic [15:0] addr;
        logic [15:0] ctl;
        logic [7:0] data;
        logic [18:0] idx;
        pick = $urandom_range(0, 99);
        data = $urandom;
        if (pick < 30) begin
            case ($urandom_range(0, 4))
                0, 1: addr = rom_addr();
                2, 3: addr = ram_addr();
                default: begin
                    addr = $urandom;
                    addr[15] = 1'b1;
                    if (addr[14:13] == 2'b01) addr[14] = 1'b1;
                end
            endcase
            read_at(addr);
        end else if (pick < 55) begin
            addr = $urandom;
            addr[15] = 1'b0;
            if (addr[15:13] == RGN_RAM_ENABLE && $urandom_range(0, 2) != 0) data[3:0] = 4'hA;
            write_at(addr, data);
        end else if (pick < 68) begin
            write_at(ram_addr(), data);
        end else if (pick < 85) begin
            // enable RAM, pick a bank, write a byte and read it back, then read a ROM address
            ctl = $urandom_range(0, 16'h1FFF);
            ctl[8] = 1'b0;
            data[3:0] = 4'hA;
            write_at(ctl, data);
            ctl = $urandom;
            ctl[15:13] = RGN_UPPER_BANK;
            write_at(ctl, $urandom_range(0, 15));
            addr = ram_addr();
            write_at(addr, $urandom);
            read_at(addr);
            read_at(rom_addr());
        end else if (pick < 96) begin
            if ($urandom_range(0, 1) != 0) idx = $urandom;
            else idx = cart_sb.rom_offset(rom_addr());
            send_item(ACT_PRELOAD, $urandom, data, idx);
        end else begin
            send_item(ACT_UNUSED, $urandom, data, $urandom);
        end
    endtask

    // Result receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) cart_sb.check_read(out_ch.read_data);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int target;
        cart_sb = new();
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= CFG_CART_TYPE;
        i_cfg_data           <= 8'h00;
        in_ch.valid          <= 1'b0;
        in_ch.action         <= ACT_READ;
        in_ch.bus_address    <= 16'h0000;
        in_ch.bus_data       <= 8'h00;
        in_ch.rom_load_index <= 19'h00000;
        idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) settle();
            calm = (p == NUM_PHASES - 1);
            case (p)
                0: begin load_config(8'h01, 8'h05, 8'h03, 8'h20); idle_pct = 0;  end
                1: begin load_config(8'h03, 8'h08, 8'h04, 8'hFF); idle_pct = 25; end
                2: begin load_config(8'h05, 8'h03, 8'h00, 8'h01); idle_pct = 10; end
                3: begin load_config(8'h13, 8'h06, 8'h05, 8'h14); idle_pct = 30; end
                4: begin load_config(8'h19, 8'h08, 8'h04, 8'h20); idle_pct = 0;  end
                5: begin load_config(8'h00, 8'h00, 8'h01, 8'h02); idle_pct = 15; end
                6: begin load_config(8'hFF, 8'hFF, 8'hFF, 8'hC0); idle_pct = 25; end
                7: begin load_config(8'h1E, 8'h09, 8'h02, 8'h07); idle_pct = 10; end
                default: begin load_config(8'h02, 8'h04, 8'h03, 8'h0B); idle_pct = 0; end
            endcase
            if (p == 0) begin
                directed();
            end else begin
                if (p == 3) begin
                    // hold results back so the block fills up and stalls its input
                    long_hold_req = 1'b1;
                    repeat (24) read_at(($urandom_range(0, 1) != 0) ? rom_addr() : ram_addr());
                end
                target = items_sent + PHASE_ITEMS;
                while (items_sent < target) random_item();
            end
        end
        settle();
        if (cart_sb.mismatches == 0 && cart_sb.read_bytes_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ cartridge_bank_controller.f @@
rtl/core/cbc_pkg.sv
rtl/core/cbc_in_if.sv
rtl/core/cbc_out_if.sv
rtl/core/cbc_ram.sv
rtl/core/cartridge_bank_controller.sv
dv/tb_cartridge_bank_controller.sv
